### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the allocator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FFA_ASSERT(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Same, on the signals named clk and rst_n in the enclosing scope.
`define FFA_CHECK(label, prop, msg) `FFA_ASSERT(label, clk, rst_n, prop, msg)

`endif

### hw/rtl/ffa_pkg.sv
// Package of the first-fit frame allocator: widths, codes, defaults and
// the structs between the controller and the scan datapath. No dependencies.
package ffa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int OWNER_BITS_DEF = 8;
    localparam int OWNER_BITS_MAX = 16;

    localparam int ADDR_W    = 24;
    localparam int END_W     = 25;
    localparam int BYTES_W   = 25;
    localparam int REQ_W     = 17;
    localparam int LOG2_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int USE_W     = 7;
    localparam int OWNER_IN_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0]   MIN_REQ          = 17'd64;
    localparam logic [REQ_W-1:0]   MAX_REQ          = 17'd65536;
    localparam logic [BYTES_W-1:0] MEM_LIMIT        = 25'd16777216;
    localparam logic [LOG2_W-1:0]  FRAME_LOG2_MAX   = 5'd16;
    localparam logic [BYTES_W-1:0] TOTAL_RESET      = 25'd16384;
    localparam logic [LOG2_W-1:0]  FRAME_LOG2_RESET = 5'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_GAP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LOG2  = 1'd1;

    typedef struct packed {
        logic clear;
        logic valid;
        logic tail;
    } scan_ctl_t;

    typedef struct packed {
        logic [BYTES_W-1:0] gap_sum;
        logic               res_found;
        logic [ADDR_W-1:0]  res_start;
        logic               fit_found;
        logic [ADDR_W-1:0]  fit_addr;
        logic               done;
    } scan_res_t;

endpackage

### hw/rtl/ffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ffa_scan.sv
// Two-stage scan datapath over the block table stream: gap total, resident
// owner lookup and first-fit search. Depends on ffa_pkg.
module ffa_scan
    import ffa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  scan_ctl_t                          ctl,
    input  logic [ADDR_W-1:0]                  ent_start,
    input  logic [END_W-1:0]                   ent_end,
    input  logic [OWNER_BITS-1:0]              ent_owner,
    input  logic [OWNER_BITS-1:0]              own,
    input  logic [BYTES_W-1:0]                 top,
    input  logic [REQ_W-1:0]                   fmask,
    input  logic [REQ_W-1:0]                   need,
    output scan_res_t                          res,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]    fit_pos
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int AL_W  = END_W + 1;
    localparam int CMP_W = END_W + 2;

    // Stage one: aligned end of the previous block and the gap before this one.
    logic [END_W-1:0] last_reg, last_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_tail_reg, s1_tail_next;
    logic [END_W-1:0] s1_start_reg;
    logic [AL_W-1:0]  s1_al_reg;
    logic [END_W-1:0] s1_gap_reg;
    logic             s1_match_reg;

    logic [END_W-1:0] start_in;
    logic [AL_W-1:0]  fmask_w;
    logic [AL_W-1:0]  al_in;
    logic [END_W-1:0] gap_in;

    // Stage two: accumulators.
    logic [BYTES_W-1:0] sum_reg, sum_next;
    logic               res_found_reg, res_found_next;
    logic [ADDR_W-1:0]  res_start_reg, res_start_next;
    logic               fit_found_reg, fit_found_next;
    logic [ADDR_W-1:0]  fit_addr_reg, fit_addr_next;
    logic [CNT_W-1:0]   fit_pos_reg, fit_pos_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               fit;

    // The end-of-table item stands in for an entry that starts at the top.
    assign start_in = ctl.tail ? top : {1'b0, ent_start};
    assign fmask_w  = {{(AL_W - REQ_W){1'b0}}, fmask};
    assign al_in    = ({1'b0, last_reg} + fmask_w) & ~fmask_w;
    assign gap_in   = (start_in > last_reg) ? (start_in - last_reg) : '0;

    assign fit = {2'b00, s1_start_reg}
                 >= ({1'b0, s1_al_reg} + {{(CMP_W - REQ_W){1'b0}}, need});

    always_comb
    begin
        last_next      = last_reg;
        s1_valid_next  = ctl.valid;
        s1_tail_next   = ctl.tail;
        sum_next       = sum_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        fit_found_next = fit_found_reg;
        fit_addr_next  = fit_addr_reg;
        fit_pos_next   = fit_pos_reg;
        idx_next       = idx_reg;
        if (ctl.clear)
        begin
            last_next      = '0;
            sum_next       = '0;
            res_found_next = 1'b0;
            fit_found_next = 1'b0;
            idx_next       = '0;
        end
        else
        begin
            if (ctl.valid && !ctl.tail)
            begin
                last_next = ent_end;
            end
            if (s1_valid_reg)
            begin
                sum_next = sum_reg + s1_gap_reg;
                if (s1_match_reg && !res_found_reg)
                begin
                    res_found_next = 1'b1;
                    res_start_next = s1_start_reg[ADDR_W-1:0];
                end
                if (fit && !fit_found_reg)
                begin
                    fit_found_next = 1'b1;
                    fit_addr_next  = s1_al_reg[ADDR_W-1:0];
                    fit_pos_next   = idx_reg;
                end
                if (!s1_tail_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_tail_reg   <= 1'b0;
            sum_reg       <= '0;
            res_found_reg <= 1'b0;
            fit_found_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            last_reg      <= last_next;
            s1_valid_reg  <= s1_valid_next;
            s1_tail_reg   <= s1_tail_next;
            sum_reg       <= sum_next;
            res_found_reg <= res_found_next;
            fit_found_reg <= fit_found_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_start_reg  <= start_in;
        s1_al_reg     <= al_in;
        s1_gap_reg    <= gap_in;
        s1_match_reg  <= (ent_owner == own) && !ctl.tail;
        res_start_reg <= res_start_next;
        fit_addr_reg  <= fit_addr_next;
        fit_pos_reg   <= fit_pos_next;
    end

    assign res.gap_sum   = sum_reg;
    assign res.res_found = res_found_reg;
    assign res.res_start = res_start_reg;
    assign res.fit_found = fit_found_reg;
    assign res.fit_addr  = fit_addr_reg;
    assign res.done      = s1_valid_reg && s1_tail_reg;
    assign fit_pos       = fit_pos_reg;

endmodule

### hw/rtl/first_fit_frame_allocator_top.sv
// The done strobe of an item follows a scan of every entry in the table; an insertion
// at position P then shifts the entries from P upward by one before it writes the new
// entry. One table entry is read per cycle for the scan and the shift.
// Throughput: one item at a time; busy is high while it is at work.
// Reset clears the controller, the entry count and the configuration to its defaults;
// the table memory is not swept. Depends on ffa_pkg, ffa_ram and ffa_scan.
module first_fit_frame_allocator_top
    import ffa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [OWNER_IN_W-1:0] owner_id,
    input  logic [REQ_W-1:0]      request_bytes,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     start_address,
    output logic [BYTES_W-1:0]    free_bytes,
    output logic [USE_W-1:0]      blocks_in_use,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTES_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int WORD_W = OWNER_BITS + END_W + ADDR_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_WRNEW  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [BYTES_W-1:0]   total_reg, total_next;
    logic [LOG2_W-1:0]    flog_reg, flog_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]     wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]     sh_k_reg, sh_k_next;
    logic                 sh_pend_reg, sh_pend_next;
    logic [IDX_W-1:0]     sh_wa_reg, sh_wa_next;
    logic                 dv_reg, dv_next;
    logic                 dtail_reg, dtail_next;
    logic                 done_reg, done_next;
    logic                 cmd_reg, cmd_next;
    logic [OWNER_BITS-1:0] own_reg, own_next;
    logic                 bad_reg, bad_next;
    logic [REQ_W-1:0]     need_reg, need_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [BYTES_W-1:0]   free_reg, free_next;

    logic [BYTES_W-1:0]        top;
    logic [LOG2_W-1:0]         lg;
    logic [REQ_W-1:0]          frame;
    logic [REQ_W-1:0]          fmask;
    logic [OWNER_BITS_MAX-1:0] own_wide;
    logic                      req_bad;
    logic [15:0]               cnt_wide;

    logic                 accept;
    logic [IDX_W-1:0]     rd_addr;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [WORD_W-1:0]    wdata;
    logic [WORD_W-1:0]    rd_data;
    logic [ADDR_W-1:0]    rd_start;
    logic [END_W-1:0]     rd_end;
    logic [OWNER_BITS-1:0] rd_owner;
    logic                 d_keep;
    logic [CNT_W-1:0]     shk_dec;
    logic [END_W-1:0]     new_end;

    scan_ctl_t            scan_ctl;
    scan_res_t            scan_res;
    logic [CNT_W-1:0]     fit_pos;

    assign top      = (total_reg > MEM_LIMIT) ? MEM_LIMIT : total_reg;
    assign lg       = (flog_reg > FRAME_LOG2_MAX) ? FRAME_LOG2_MAX : flog_reg;
    assign frame    = REQ_W'(1) << lg;
    assign fmask    = frame - 1'b1;
    assign own_wide = OWNER_BITS_MAX'(owner_id);
    assign req_bad  = (request_bytes < MIN_REQ) || (request_bytes > MAX_REQ)
                      || ((request_bytes & (request_bytes - 1'b1)) != '0);

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign rd_start = rd_data[ADDR_W-1:0];
    assign rd_end   = rd_data[ADDR_W +: END_W];
    assign rd_owner = rd_data[ADDR_W + END_W +: OWNER_BITS];

    // During a free pass, entries of other owners are written back compacted.
    assign d_keep   = (rd_owner != own_reg);
    assign shk_dec  = sh_k_reg - 1'b1;
    assign rd_addr  = (state_reg == S_SHIFT) ? shk_dec[IDX_W-1:0] : rd_cnt_reg[IDX_W-1:0];
    assign new_end  = {1'b0, scan_res.fit_addr} + {{(END_W - REQ_W){1'b0}}, need_reg};

    always_comb
    begin
        we    = 1'b0;
        waddr = wr_cnt_reg[IDX_W-1:0];
        wdata = rd_data;
        priority if (state_reg == S_WRNEW)
        begin
            we    = 1'b1;
            waddr = fit_pos[IDX_W-1:0];
            wdata = {own_reg, new_end, scan_res.fit_addr};
        end
        else if (sh_pend_reg)
        begin
            we    = 1'b1;
            waddr = sh_wa_reg;
        end
        else if (dv_reg && !dtail_reg && (cmd_reg == CMD_FREE) && d_keep)
        begin
            we = 1'b1;
        end
    end

    assign scan_ctl.clear = accept;
    assign scan_ctl.valid = dv_reg && (dtail_reg || (cmd_reg == CMD_ALLOC) || d_keep);
    assign scan_ctl.tail  = dtail_reg;

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        flog_next    = flog_reg;
        count_next   = count_reg;
        rd_cnt_next  = rd_cnt_reg;
        wr_cnt_next  = wr_cnt_reg;
        sh_k_next    = sh_k_reg;
        sh_pend_next = 1'b0;
        sh_wa_next   = sh_wa_reg;
        dv_next      = 1'b0;
        dtail_next   = 1'b0;
        done_next    = 1'b0;
        cmd_next     = cmd_reg;
        own_next     = own_reg;
        bad_next     = bad_reg;
        need_next    = need_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;
        free_next    = free_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TOTAL_BYTES: total_next = cfg_data;
                REG_FRAME_LOG2:  flog_next  = cfg_data[LOG2_W-1:0];
                default:         total_next = total_reg;
            endcase
        end

        if (dv_reg && !dtail_reg && (cmd_reg == CMD_FREE) && d_keep)
        begin
            wr_cnt_next = wr_cnt_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    own_next    = own_wide[OWNER_BITS-1:0];
                    bad_next    = req_bad;
                    // Both sizes are powers of two, so rounding up is the larger one.
                    need_next   = (request_bytes > frame) ? request_bytes : frame;
                    rd_cnt_next = '0;
                    wr_cnt_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                dv_next = 1'b1;
                if (rd_cnt_reg < count_reg)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    dtail_next = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (scan_res.done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                free_next  = scan_res.gap_sum;
                addr_next  = '0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (cmd_reg == CMD_FREE)
                begin
                    status_next = ST_OK;
                    count_next  = wr_cnt_reg;
                end
                else
                begin
                    priority if (bad_reg)
                    begin
                        status_next = ST_BAD_SIZE;
                    end
                    else if (scan_res.res_found)
                    begin
                        status_next = ST_OK;
                        addr_next   = scan_res.res_start;
                    end
                    else if (count_reg >= CNT_W'(MAX_BLOCKS))
                    begin
                        status_next = ST_FULL;
                    end
                    else if (scan_res.fit_found)
                    begin
                        sh_k_next  = count_reg;
                        done_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        status_next = ST_NO_GAP;
                    end
                end
            end
            S_SHIFT:
            begin
                // Move entries up by one, from the top down to the insert point.
                if (sh_k_reg > fit_pos)
                begin
                    sh_pend_next = 1'b1;
                    sh_wa_next   = sh_k_reg[IDX_W-1:0];
                    sh_k_next    = shk_dec;
                end
                else
                begin
                    state_next = S_WRNEW;
                end
            end
            S_WRNEW:
            begin
                count_next  = count_reg + 1'b1;
                status_next = ST_OK;
                addr_next   = scan_res.fit_addr;
                free_next   = scan_res.gap_sum - {{(BYTES_W - REQ_W){1'b0}}, need_reg};
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= TOTAL_RESET;
            flog_reg    <= FRAME_LOG2_RESET;
            count_reg   <= '0;
            rd_cnt_reg  <= '0;
            wr_cnt_reg  <= '0;
            sh_k_reg    <= '0;
            sh_pend_reg <= 1'b0;
            dv_reg      <= 1'b0;
            dtail_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            flog_reg    <= flog_next;
            count_reg   <= count_next;
            rd_cnt_reg  <= rd_cnt_next;
            wr_cnt_reg  <= wr_cnt_next;
            sh_k_reg    <= sh_k_next;
            sh_pend_reg <= sh_pend_next;
            dv_reg      <= dv_next;
            dtail_reg   <= dtail_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_wa_reg  <= sh_wa_next;
        cmd_reg    <= cmd_next;
        own_reg    <= own_next;
        bad_reg    <= bad_next;
        need_reg   <= need_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        free_reg   <= free_next;
    end

    ffa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ffa_scan #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .OWNER_BITS (OWNER_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .ent_start (rd_start),
        .ent_end   (rd_end),
        .ent_owner (rd_owner),
        .own       (own_reg),
        .top       (top),
        .fmask     (fmask),
        .need      (need_reg),
        .res       (scan_res),
        .fit_pos   (fit_pos)
    );

    assign cnt_wide      = 16'(count_reg);
    assign done          = done_reg;
    assign status        = status_reg;
    assign start_address = addr_reg;
    assign free_bytes    = free_reg;
    assign blocks_in_use = cnt_wide[USE_W-1:0];

endmodule

### hw/rtl/ffa_checker.sv
// Port-level checker for the first-fit frame allocator, bound to its top level.
// Depends on ffa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffa_checker
    import ffa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [ADDR_W-1:0]   start_address
);

    // A result appears only once the block has gone back to idle.
    `FFA_CHECK(a_done_idle, done |-> !busy, "result strobe while busy")
    // An accepted item keeps the block busy in the next cycle.
    `FFA_CHECK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
    // The block only becomes busy by accepting an item.
    `FFA_CHECK(a_busy_cause, $rose(busy) |-> $past(start), "busy rose without a start")
    // Each item gives a single one-cycle result.
    `FFA_CHECK(a_done_pulse, done |=> !done, "result strobe held longer than a cycle")
    // Failed allocations report no address.
    `FFA_CHECK(a_fail_addr, (done && (status != ST_OK)) |-> (start_address == '0), "failure with address")

endmodule

bind first_fit_frame_allocator_top ffa_checker u_ffa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .start_address (start_address)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for first_fit_frame_allocator_top: a directed table and random phases, each
// result checked against the row's given values or a predictor with its own table copy.
// Depends on ffa_pkg and the allocator RTL only.
module tb;
    import ffa_pkg::*;

    localparam int TABLE_DEPTH   = MAX_BLOCKS_DEF;
    localparam int OWNER_POOL    = 80;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * MAX_BLOCKS_DEF + 20;
    localparam int PHASE_COUNT   = 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [BYTES_W-1:0]  free;
        logic [USE_W-1:0]    used;
    } alloc_result_t;

    typedef struct {
        logic                  c;
        logic [OWNER_IN_W-1:0] own;
        logic [REQ_W-1:0]      req;
        bit                    known;
        alloc_result_t         want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [OWNER_IN_W-1:0] owner_id;
    logic [REQ_W-1:0]      request_bytes;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [ADDR_W-1:0]     start_address;
    logic [BYTES_W-1:0]    free_bytes;
    logic [USE_W-1:0]      blocks_in_use;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTES_W-1:0]    cfg_data;

    // Shadow copy of the block table and the configuration.
    logic [ADDR_W-1:0]     seg_start [TABLE_DEPTH];
    logic [END_W-1:0]      seg_end   [TABLE_DEPTH];
    logic [OWNER_IN_W-1:0] seg_owner [TABLE_DEPTH];
    int                    seg_count;
    logic [BYTES_W-1:0]    mem_cfg;
    logic [LOG2_W-1:0]     frame_cfg;

    alloc_result_t expected_results[$];
    stim_row_t     directed_rows[$];
    int            mismatches;
    int            stall_cycles;

    first_fit_frame_allocator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .owner_id     (owner_id),
        .request_bytes(request_bytes),
        .done         (done),
        .status       (status),
        .start_address(start_address),
        .free_bytes   (free_bytes),
        .blocks_in_use(blocks_in_use),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint round_up(input longint v, input longint f);
        return ((v + f - 1) / f) * f;
    endfunction

    // Applies one request to the shadow table and returns the result it should produce.
    function automatic alloc_result_t predict_allocation(input logic c,
                                                         input logic [OWNER_IN_W-1:0] own,
                                                         input logic [REQ_W-1:0] req);
        alloc_result_t r;
        longint        top, f, need, last, al, sum, rq, fin;
        int            i, k, w, pos;
        bit            resident;
        r = '0;
        top = (mem_cfg > MEM_LIMIT) ? longint'(MEM_LIMIT) : longint'(mem_cfg);
        rq = longint'(req);
        if (c == CMD_ALLOC)
        begin
            resident = 1'b0;
            pos = -1;
            if (rq < longint'(MIN_REQ) || rq > longint'(MAX_REQ) || (rq & (rq - 1)) != 0)
            begin
                r.status = ST_BAD_SIZE;
            end
            else
            begin
                for (i = 0; i < seg_count && !resident; i++)
                begin
                    if (seg_owner[i] == own)
                    begin
                        resident = 1'b1;
                        r.addr = seg_start[i];
                    end
                end
                if (resident)
                begin
                    r.status = ST_OK;
                end
                else if (seg_count >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    f = longint'(1)
                        << ((frame_cfg > FRAME_LOG2_MAX) ? FRAME_LOG2_MAX : frame_cfg);
                    need = round_up(rq, f);
                    last = 0;
                    al = 0;
                    // First fit: the gap starts at the aligned end of the previous block.
                    for (i = 0; i < seg_count && pos < 0; i++)
                    begin
                        al = round_up(last, f);
                        if (longint'(seg_start[i]) >= al && longint'(seg_start[i]) - al >= need)
                            pos = i;
                        else
                            last = longint'(seg_end[i]);
                    end
                    if (pos < 0)
                    begin
                        al = round_up(last, f);
                        if (top >= al && top - al >= need)
                            pos = seg_count;
                    end
                    if (pos < 0)
                    begin
                        r.status = ST_NO_GAP;
                    end
                    else
                    begin
                        for (k = seg_count; k > pos; k--)
                        begin
                            seg_start[k] = seg_start[k-1];
                            seg_end[k]   = seg_end[k-1];
                            seg_owner[k] = seg_owner[k-1];
                        end
                        fin = al + need;
                        seg_start[pos] = al[ADDR_W-1:0];
                        seg_end[pos]   = fin[END_W-1:0];
                        seg_owner[pos] = own;
                        seg_count++;
                        r.status = ST_OK;
                        r.addr = al[ADDR_W-1:0];
                    end
                end
            end
        end
        else
        begin
            w = 0;
            for (i = 0; i < seg_count; i++)
            begin
                if (seg_owner[i] != own)
                begin
                    seg_start[w] = seg_start[i];
                    seg_end[w]   = seg_end[i];
                    seg_owner[w] = seg_owner[i];
                    w++;
                end
            end
            seg_count = w;
        end
        sum = 0;
        last = 0;
        for (i = 0; i < seg_count; i++)
        begin
            if (longint'(seg_start[i]) > last)
                sum += longint'(seg_start[i]) - last;
            last = longint'(seg_end[i]);
        end
        if (last < top)
            sum += top - last;
        r.free = sum[BYTES_W-1:0];
        r.used = seg_count[USE_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t directed_row(input logic c, input logic [OWNER_IN_W-1:0] own,
                                               input logic [REQ_W-1:0] req, input bit known,
                                               input logic [STATUS_W-1:0] st,
                                               input logic [ADDR_W-1:0] a,
                                               input logic [BYTES_W-1:0] fb,
                                               input logic [USE_W-1:0] u);
        stim_row_t s;
        s.c = c;
        s.own = own;
        s.req = req;
        s.known = known;
        s.want.status = st;
        s.want.addr = a;
        s.want.free = fb;
        s.want.used = u;
        return s;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(input stim_row_t s);
        directed_rows.insert(directed_rows.size(), s);
    endfunction

    // Presents one item and holds it until the block takes it.
    task automatic send_request(input logic c, input logic [OWNER_IN_W-1:0] own,
                                input logic [REQ_W-1:0] req, input bit known,
                                input alloc_result_t want);
        alloc_result_t predicted;
        @(negedge clk);
        start = 1'b1;
        cmd = c;
        owner_id = own;
        request_bytes = req;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = predict_allocation(c, own, req);
        expected_results.insert(expected_results.size(), known ? want : predicted);
    endtask

    task automatic pause_sender();
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain_results();
        pause_sender();
        while (expected_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_TOTAL_BYTES)
            mem_cfg = val;
        else
            frame_cfg = val[LOG2_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly valid allocations and frees over a small owner pool, so that the table fills
    // and drains; the early part of a phase frees rarely to push it to full.
    task automatic random_request(input int idx, input int phase_len);
        int                    r, sh, alloc_pct, free_pct;
        logic                  c;
        logic [OWNER_IN_W-1:0] own;
        logic [REQ_W-1:0]      req;
        alloc_pct = (idx < phase_len / 3) ? 90 : 68;
        free_pct = (idx < phase_len / 3) ? 93 : 90;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
        begin
            c = CMD_ALLOC;
            own = OWNER_IN_W'($urandom_range(0, OWNER_POOL - 1));
            sh = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 10);
            req = MIN_REQ << sh;
        end
        else if (r < free_pct)
        begin
            c = CMD_FREE;
            own = OWNER_IN_W'($urandom_range(0, OWNER_POOL - 1));
            req = REQ_W'($urandom);
        end
        else
        begin
            c = 1'($urandom_range(0, 1));
            own = OWNER_IN_W'($urandom_range(0, 255));
            req = REQ_W'($urandom_range(0, 131071));
        end
        send_request(c, own, req, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d addr %0d free %0d used %0d",
                             status, start_address, free_bytes, blocks_in_use);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (status !== want.status || start_address !== want.addr ||
                    free_bytes !== want.free || blocks_in_use !== want.used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected status %0d addr %0d free %0d used %0d",
                               want.status, want.addr, want.free, want.used);
                        $display(", got status %0d addr %0d free %0d used %0d",
                                 status, start_address, free_bytes, blocks_in_use);
                    end
                end
            end
        end
    end

    // Ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1 ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [BYTES_W-1:0] tot;
        logic [BYTES_W-1:0] lg;
        int                 idle_pct, items, p, n;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ALLOC;
        owner_id = '0;
        request_bytes = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TOTAL_BYTES;
        cfg_data = '0;
        mismatches = 0;
        stall_cycles = 0;
        seg_count = 0;
        mem_cfg = TOTAL_RESET;
        frame_cfg = FRAME_LOG2_RESET;

        // Defaults after reset: 16384 bytes, 16-byte frames.
        add_row(directed_row(CMD_ALLOC, 8'd1, 17'd64, 1, ST_OK, 0, 16320, 1));
        // A resident owner gets its block back even when the size would not fit.
        add_row(directed_row(CMD_ALLOC, 8'd1, 17'd65536, 1, ST_OK, 0, 16320, 1));
        add_row(directed_row(CMD_ALLOC, 8'd2, 17'd0, 1, ST_BAD_SIZE, 0, 16320, 1));
        add_row(directed_row(CMD_ALLOC, 8'd2, 17'd63, 1, ST_BAD_SIZE, 0, 16320, 1));
        add_row(directed_row(CMD_ALLOC, 8'd2, 17'd96, 1, ST_BAD_SIZE, 0, 16320, 1));
        add_row(directed_row(CMD_ALLOC, 8'd2, 17'd131071, 1, ST_BAD_SIZE, 0, 16320, 1));
        // A bad size wins over a resident owner.
        add_row(directed_row(CMD_ALLOC, 8'd1, 17'd100, 1, ST_BAD_SIZE, 0, 16320, 1));
        add_row(directed_row(CMD_ALLOC, 8'd2, 17'd65536, 1, ST_NO_GAP, 0, 16320, 1));
        add_row(directed_row(CMD_ALLOC, 8'd255, 17'd4096, 1, ST_OK, 64, 12224, 2));
        add_row(directed_row(CMD_ALLOC, 8'd0, 17'd128, 1, ST_OK, 4160, 12096, 3));
        add_row(directed_row(CMD_FREE, 8'd1, 17'd0, 1, ST_OK, 0, 12160, 2));
        // The hole left at the bottom is reused first.
        add_row(directed_row(CMD_ALLOC, 8'd3, 17'd64, 1, ST_OK, 0, 12096, 3));
        // Freeing an owner with no blocks still reports ok.
        add_row(directed_row(CMD_FREE, 8'd200, 17'd131071, 1, ST_OK, 0, 12096, 3));
        add_row(directed_row(CMD_ALLOC, 8'd4, 17'd8192, 1, ST_OK, 4288, 3904, 4));
        add_row(directed_row(CMD_ALLOC, 8'd5, 17'd8192, 1, ST_NO_GAP, 0, 3904, 4));
        add_row(directed_row(CMD_ALLOC, 8'd5, 17'd2048, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_FREE, 8'd255, 17'd0, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_ALLOC, 8'd6, 17'd4096, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_FREE, 8'd3, 17'd0, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_FREE, 8'd6, 17'd0, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_FREE, 8'd0, 17'd0, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_FREE, 8'd4, 17'd0, 0, ST_OK, 0, 0, 0));
        add_row(directed_row(CMD_FREE, 8'd5, 17'd0, 0, ST_OK, 0, 0, 0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (n = 0; n < directed_rows.size(); n++)
            send_request(directed_rows[n].c, directed_rows[n].own, directed_rows[n].req,
                         directed_rows[n].known, directed_rows[n].want);
        drain_results();

        // Blocks are left in place across phases, so each new setting also meets a table
        // built under the previous one.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin tot = 25'd16384;    lg = 4;  idle_pct = 9;  items = 300; end
                1: begin tot = 25'd16777216; lg = 0;  idle_pct = 9;  items = 250; end
                2: begin tot = 25'h1FFFFFF;  lg = 16; idle_pct = 9;  items = 200; end
                3: begin tot = 25'd64;       lg = 0;  idle_pct = 69; items = 100; end
                4: begin tot = 25'd1048576;  lg = 31; idle_pct = 69; items = 250; end
                5: begin tot = 25'd4096;     lg = 6;  idle_pct = 69; items = 250; end
                6: begin tot = 25'd200000;   lg = 10; idle_pct = 0;  items = 300; end
                default: begin tot = 25'd16384; lg = 2; idle_pct = 0; items = 300; end
            endcase
            write_reg(REG_TOTAL_BYTES, tot);
            write_reg(REG_FRAME_LOG2, lg);
            for (n = 0; n < items; n++)
            begin
                while ($urandom_range(0, 99) < idle_pct)
                    pause_sender();
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                random_request(n, items);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
